// ===== rtl/kms_pkg.sv =====
// Shared types and constants for the keypad matrix scanner.
// Used by the interfaces, the cells, the tick counter and the top level.
`default_nettype none

package kms_pkg;

	localparam int ROW_W    = 5;
	localparam int COLS     = 4;
	localparam int KEY_W    = ROW_W * COLS;
	localparam int PERIOD_W = 8;

	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [COLS-1:0]     drive_t;
	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [PERIOD_W-1:0] period_t;

	localparam period_t PERIOD_RESET = 8'd17;

	// Column driven on the tick that ends a scan period.
	localparam drive_t DRIVE_FIRST = 4'b0100;

	// Column driven after each capture cell takes its rows.
	localparam drive_t CELL_DRIVE [COLS] = '{4'b1000, 4'b0001, 4'b0010, 4'b0000};

	typedef struct packed {
		logic advance;
		logic restart;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/kms_if.sv =====
// Handshake interfaces for the tick, result and configuration channels.
// Depends on kms_pkg for the payload types.
`default_nettype none

interface kms_tick_if;
	logic          valid;
	logic          ready;
	kms_pkg::row_t row_sample;
	modport source (output valid, output row_sample, input ready);
	modport sink (input valid, input row_sample, output ready);
endinterface

interface kms_result_if;
	logic            valid;
	logic            ready;
	kms_pkg::drive_t column_drive;
	logic            period_end;
	kms_pkg::key_t   key_word;
	logic            key_changed;
	modport source (output valid, output column_drive, output period_end,
		output key_word, output key_changed, input ready);
	modport sink (input valid, input column_drive, input period_end,
		input key_word, input key_changed, output ready);
endinterface

interface kms_cfg_if;
	logic             valid;
	logic             ready;
	kms_pkg::period_t scan_period;
	modport source (output valid, output scan_period, input ready);
	modport sink (input valid, input scan_period, output ready);
endinterface

`default_nettype wire

// ===== rtl/kms_tick_counter.sv =====
// Tick counter and scan period register for the keypad scanner.
// Depends on kms_pkg; feeds the head of the capture cell chain.
`default_nettype none

module kms_tick_counter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic               cfg_write,
	input  wire kms_pkg::period_t   cfg_period,
	output kms_pkg::cell_ctl_t      ctl,
	output logic                    head_token
);

	kms_pkg::period_t period_q;
	kms_pkg::period_t count_q;
	kms_pkg::period_t count_next;
	logic             start_q;
	logic             wrap;

	assign count_next = count_q + kms_pkg::period_t'(1);
	assign wrap       = count_next >= period_q;

	assign ctl.advance = advance;
	assign ctl.restart = wrap;
	assign head_token  = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= kms_pkg::PERIOD_RESET;
		end else if (cfg_write) begin
			period_q <= cfg_period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			start_q <= 1'b1;
		end else if (advance) begin
			count_q <= wrap ? '0 : count_next;
			start_q <= wrap;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/kms_capture_cell.sv =====
// One capture cell: holds the rows for one column and passes the scan token on.
// Depends on kms_pkg for the row, drive and control types.
`default_nettype none

module kms_capture_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kms_pkg::cell_ctl_t   ctl,
	input  wire logic                 token_in,
	input  wire kms_pkg::row_t        row_sample,
	input  wire kms_pkg::drive_t      drive_code,
	output logic                      token_out,
	output kms_pkg::row_t             capture,
	output kms_pkg::drive_t           drive
);

	logic          token_q;
	kms_pkg::row_t capture_q;
	logic          take;

	assign take      = token_in && !ctl.restart;
	assign token_out = token_q;
	assign capture   = capture_q;
	assign drive     = take ? drive_code : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q   <= 1'b0;
			capture_q <= '0;
		end else if (ctl.advance) begin
			token_q <= take;
			if (ctl.restart) begin
				capture_q <= '0;
			end else if (token_in) begin
				capture_q <= row_sample;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/keypad_matrix_scanner.sv =====
// Top level of the 4-column by 5-row keypad matrix scanner.
// Depends on kms_pkg, kms_if, kms_tick_counter and kms_capture_cell.
//
// Every tick transfer yields one result transfer. The block takes one tick per clock
// cycle: the result sits in a single output register, and
// a new tick is taken whenever that register is empty or its result is being taken in
// the same cycle. A scan token walks down a chain of four capture cells, one cell per
// tick, so each cell latches the rows for the column driven on the tick before. At the
// end of each scan period the four captures are packed into the key word, first
// capture in the top bits. The scan period register resets to 17 ticks and may be
// written at any time the block is idle; there is no clearing pass after reset.
`default_nettype none

module keypad_matrix_scanner (
	input  wire logic     clk,
	input  wire logic     arst_n,
	kms_tick_if.sink      tick,
	kms_result_if.source  result,
	kms_cfg_if.sink       cfg
);

	logic               accept;
	kms_pkg::cell_ctl_t ctl;
	logic               head_token;
	logic               token [kms_pkg::COLS+1];
	kms_pkg::row_t      capture [kms_pkg::COLS];
	kms_pkg::drive_t    cell_drive [kms_pkg::COLS];
	kms_pkg::drive_t    drive_any;
	kms_pkg::key_t      packed_keys;
	kms_pkg::key_t      current_q;
	logic               valid_q;

	assign tick.ready = !valid_q || result.ready;
	assign cfg.ready  = 1'b1;
	assign accept     = tick.valid && tick.ready;

	kms_tick_counter u_counter (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.cfg_write  (cfg.valid),
		.cfg_period (cfg.scan_period),
		.ctl        (ctl),
		.head_token (head_token)
	);

	assign token[0] = head_token;

	for (genvar k = 0; k < kms_pkg::COLS; k++) begin : g_cell
		kms_capture_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.token_in   (token[k]),
			.row_sample (tick.row_sample),
			.drive_code (kms_pkg::CELL_DRIVE[k]),
			.token_out  (token[k+1]),
			.capture    (capture[k]),
			.drive      (cell_drive[k])
		);
	end

	always_comb begin
		drive_any = ctl.restart ? kms_pkg::DRIVE_FIRST : '0;
		for (int k = 0; k < kms_pkg::COLS; k++) begin
			drive_any = drive_any | cell_drive[k];
		end
	end

	assign packed_keys = {capture[0], capture[1], capture[2], capture[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= '0;
		end else if (accept && ctl.restart) begin
			current_q <= packed_keys;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result.column_drive <= drive_any;
			result.period_end   <= ctl.restart;
			result.key_word     <= ctl.restart ? packed_keys : current_q;
			result.key_changed  <= ctl.restart && (packed_keys != current_q);
		end
	end

	assign result.valid = valid_q;

	// The last token drops off the end of the chain.
	logic unused_token;
	assign unused_token = token[kms_pkg::COLS];

endmodule

`default_nettype wire

// ===== rtl/kms_checker.sv =====
// Port-level checks for the keypad matrix scanner and the bind that attaches them.
// Depends on kms_pkg and on the top level keypad_matrix_scanner.
`default_nettype none

module kms_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            res_valid,
	input wire logic            res_ready,
	input wire kms_pkg::drive_t column_drive,
	input wire logic            period_end,
	input wire kms_pkg::key_t   key_word,
	input wire logic            key_changed
);

	a_changed_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && key_changed |-> period_end)
		else $error("key_changed raised outside a period end");

	a_drive_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0(column_drive))
		else $error("more than one column driven");

	a_end_drives_first: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && period_end |-> column_drive == kms_pkg::DRIVE_FIRST)
		else $error("period end did not drive the first column");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(key_word) && $stable(period_end))
		else $error("stalled result changed");

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.column_drive (result.column_drive),
	.period_end   (result.period_end),
	.key_word     (result.key_word),
	.key_changed  (result.key_changed)
);

`default_nettype wire
